[rtl/link_join_supervisor_defines.svh]
// Assertion macros used by the link join supervisor top module.
`ifndef LINK_JOIN_SUPERVISOR_DEFINES_SVH
`define LINK_JOIN_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LJS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LJS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/ljs_pkg.sv]
// Types and constants of the link join supervisor.
package ljs_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_CONNECTING = 2'd1,
        MODE_UP         = 2'd2,
        MODE_DOWN       = 2'd3
    } mode_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_WAIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_JOIN_TIMEOUT  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] POLL_INTERVAL_RESET = 31'd1000;
    localparam logic [CFG_DATA_W-1:0] RETRY_WAIT_RESET    = 31'd10000;
    localparam logic [CFG_DATA_W-1:0] JOIN_TIMEOUT_RESET  = 31'd15000;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] poll_interval;
        logic [CFG_DATA_W-1:0] retry_wait;
        logic [CFG_DATA_W-1:0] join_timeout;
    } ljs_cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_time;
        logic        link_up;
        logic        link_failed;
        logic        connect_accepted;
        logic [31:0] link_address;
    } ljs_item_t;

    typedef struct packed {
        logic [1:0]  link_state;
        logic        connect_request;
        logic [31:0] held_address;
    } ljs_result_t;

endpackage

[rtl/ljs_ifs.sv]
// Handshake interfaces for the command and status channels.
interface ljs_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] now_time;
    logic        link_up;
    logic        link_failed;
    logic        connect_accepted;
    logic [31:0] link_address;

    modport source (
        output valid, cmd, now_time, link_up, link_failed, connect_accepted, link_address,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_time, link_up, link_failed, connect_accepted, link_address,
        output ready
    );
endinterface

interface ljs_status_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_state;
    logic        connect_request;
    logic [31:0] held_address;

    modport source (
        output valid, link_state, connect_request, held_address,
        input  ready
    );
    modport sink (
        input  valid, link_state, connect_request, held_address,
        output ready
    );
endinterface

[rtl/ljs_cfg.sv]
// Configuration registers of the link join supervisor.
module ljs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ljs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ljs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ljs_pkg::ljs_cfg_t               cfg
);
    import ljs_pkg::*;

    ljs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval <= POLL_INTERVAL_RESET;
            cfg_reg.retry_wait    <= RETRY_WAIT_RESET;
            cfg_reg.join_timeout  <= JOIN_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_INTERVAL: cfg_reg.poll_interval <= cfg_data;
                CFG_RETRY_WAIT:    cfg_reg.retry_wait    <= cfg_data;
                CFG_JOIN_TIMEOUT:  cfg_reg.join_timeout  <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

[rtl/ljs_core.sv]
// Supervisor state registers and the per-word update logic.
module ljs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  ljs_pkg::ljs_item_t  item,
    input  ljs_pkg::ljs_cfg_t   cfg,
    output ljs_pkg::ljs_result_t result
);
    import ljs_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] next_poll_reg, next_poll_next;
    logic [31:0] retry_time_reg, retry_time_next;
    logic [31:0] join_deadline_reg, join_deadline_next;
    logic [31:0] address_reg, address_next;
    logic        request;

    logic [31:0] poll_sum, retry_sum, join_sum;
    logic [31:0] poll_diff, retry_diff, join_diff;
    logic        poll_due, retry_due, join_due;

    assign poll_sum  = item.now_time + {1'b0, cfg.poll_interval};
    assign retry_sum = item.now_time + {1'b0, cfg.retry_wait};
    assign join_sum  = item.now_time + {1'b0, cfg.join_timeout};

    assign poll_diff  = item.now_time - next_poll_reg;
    assign retry_diff = item.now_time - retry_time_reg;
    assign join_diff  = item.now_time - join_deadline_reg;

    assign poll_due  = !poll_diff[31];
    assign retry_due = !retry_diff[31];
    assign join_due  = !join_diff[31];

    always_comb
    begin
        mode_next          = mode_reg;
        next_poll_next     = next_poll_reg;
        retry_time_next    = retry_time_reg;
        join_deadline_next = join_deadline_reg;
        address_next       = address_reg;
        request            = 1'b0;

        priority if (item.cmd)
        begin
            request        = 1'b1;
            next_poll_next = poll_sum;
            if (item.connect_accepted)
            begin
                mode_next          = MODE_CONNECTING;
                join_deadline_next = join_sum;
            end
            else
            begin
                mode_next       = MODE_DOWN;
                retry_time_next = retry_sum;
            end
        end
        else if (mode_reg != MODE_IDLE && poll_due)
        begin
            next_poll_next = poll_sum;
            priority if (item.link_up)
            begin
                if (mode_reg != MODE_UP)
                begin
                    address_next = item.link_address;
                    mode_next    = MODE_UP;
                end
            end
            else if (mode_reg == MODE_UP ||
                     (mode_reg == MODE_CONNECTING && (item.link_failed || join_due)))
            begin
                address_next    = '0;
                mode_next       = MODE_DOWN;
                retry_time_next = retry_sum;
            end
            else if (mode_reg == MODE_DOWN && retry_due)
            begin
                request = 1'b1;
                if (item.connect_accepted)
                begin
                    mode_next          = MODE_CONNECTING;
                    join_deadline_next = join_sum;
                end
                else
                begin
                    retry_time_next = retry_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            next_poll_reg     <= '0;
            retry_time_reg    <= '0;
            join_deadline_reg <= '0;
            address_reg       <= '0;
        end
        else if (step_en)
        begin
            mode_reg          <= mode_next;
            next_poll_reg     <= next_poll_next;
            retry_time_reg    <= retry_time_next;
            join_deadline_reg <= join_deadline_next;
            address_reg       <= address_next;
        end
    end

    assign result.link_state      = mode_next;
    assign result.connect_request = request;
    assign result.held_address    = (mode_next == MODE_UP) ? address_next : 32'd0;
endmodule

[rtl/link_join_supervisor.sv]
// Link join supervisor: a word on the command channel yields one status word.
//
// The command channel carries a poll tick or a start command with the current
// millisecond time and the radio's link verdict; the status channel returns the
// link state after that word, whether a connect attempt was started, and the
// held address. Both channels move a word when valid and ready are high.
// The configuration port writes poll interval, retry wait and join timeout by
// index; writes must be made only while no word is in flight, which the block
// itself does not enforce. An accepted word waits in the input register, where
// the state update is computed, and moves to the status register once that
// register is empty or being taken. One word is taken every cycle while the
// receiver keeps ready high; the combinational update of the small state
// registers sets this rate.
// Reset empties both registers, sets the mode to idle with all deadlines and
// the address at zero, and restores the register defaults.
// When the receiver stalls, the status word holds, the input register keeps
// one more word, and ready drops until the status word is taken.
`include "link_join_supervisor_defines.svh"

module link_join_supervisor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ljs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ljs_pkg::CFG_DATA_W-1:0]  cfg_data,
    ljs_cmd_if.sink                         cmd_ch,
    ljs_status_if.source                    status_ch
);
    import ljs_pkg::*;

    ljs_cfg_t    cfg;
    ljs_item_t   item_reg;
    logic        item_valid_reg;
    ljs_result_t result;
    ljs_result_t status_reg;
    logic        status_valid_reg;
    logic        advance;
    logic        take;

    assign advance      = item_valid_reg && (!status_valid_reg || status_ch.ready);
    assign cmd_ch.ready = !item_valid_reg || advance;
    assign take         = cmd_ch.valid && cmd_ch.ready;

    ljs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ljs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                status_valid_reg <= 1'b1;
            end
            else if (status_ch.ready)
            begin
                status_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd              <= cmd_ch.cmd;
            item_reg.now_time         <= cmd_ch.now_time;
            item_reg.link_up          <= cmd_ch.link_up;
            item_reg.link_failed      <= cmd_ch.link_failed;
            item_reg.connect_accepted <= cmd_ch.connect_accepted;
            item_reg.link_address     <= cmd_ch.link_address;
        end
        if (advance)
        begin
            status_reg <= result;
        end
    end

    assign status_ch.valid           = status_valid_reg;
    assign status_ch.link_state      = status_reg.link_state;
    assign status_ch.connect_request = status_reg.connect_request;
    assign status_ch.held_address    = status_reg.held_address;

    `LJS_ASSERT_NOW(a_address_only_when_up,
        status_valid_reg && status_reg.held_address != 32'd0,
        status_reg.link_state == MODE_UP,
        "held address is nonzero while the link is not up")
    `LJS_ASSERT_NOW(a_request_state,
        status_valid_reg && status_reg.connect_request,
        status_reg.link_state == MODE_CONNECTING || status_reg.link_state == MODE_DOWN,
        "connect request reported outside connecting or down")
    `LJS_ASSERT_NEXT(a_advance_fills_status,
        advance,
        status_valid_reg,
        "status register empty after a word advanced")
    `LJS_ASSERT_NEXT(a_stalled_word_kept,
        item_valid_reg && !advance,
        item_valid_reg,
        "stalled input word was dropped")
endmodule

[test/tb_link_join_supervisor.sv]
// Testbench of the link join supervisor: directed table, then random words against a predictor.
`timescale 1ns / 100ps

module tb_link_join_supervisor;
    import ljs_pkg::*;

    typedef struct {
        ljs_item_t   word;
        bit          typed;
        ljs_result_t status;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ljs_cmd_if    cmd_if ();
    ljs_status_if status_if ();

    link_join_supervisor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ch    (cmd_if),
        .status_ch (status_if)
    );

    logic [CFG_DATA_W-1:0] shadow_poll_interval = POLL_INTERVAL_RESET;
    logic [CFG_DATA_W-1:0] shadow_retry_wait    = RETRY_WAIT_RESET;
    logic [CFG_DATA_W-1:0] shadow_join_timeout  = JOIN_TIMEOUT_RESET;
    mode_t                 shadow_mode          = MODE_IDLE;
    logic [31:0]           shadow_next_poll     = '0;
    logic [31:0]           shadow_retry_at      = '0;
    logic [31:0]           shadow_join_at       = '0;
    logic [31:0]           shadow_address       = '0;

    ljs_result_t pending_status[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    bit          quiet = 0;
    bit          squeeze_req = 0;
    logic [31:0] gen_time = '0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit deadline_reached(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return !d[31];
    endfunction

    function automatic void start_attempt(logic [31:0] now, bit accepted);
        if (accepted)
        begin
            shadow_mode    = MODE_CONNECTING;
            shadow_join_at = now + {1'b0, shadow_join_timeout};
        end
        else
        begin
            shadow_mode     = MODE_DOWN;
            shadow_retry_at = now + {1'b0, shadow_retry_wait};
        end
    endfunction

    function automatic void drop_link(logic [31:0] now);
        shadow_address  = '0;
        shadow_mode     = MODE_DOWN;
        shadow_retry_at = now + {1'b0, shadow_retry_wait};
    endfunction

    function automatic ljs_result_t supervise_step(ljs_item_t w);
        ljs_result_t r;
        bit          req;
        req = 1'b0;
        if (w.cmd)
        begin
            start_attempt(w.now_time, w.connect_accepted);
            req              = 1'b1;
            shadow_next_poll = w.now_time + {1'b0, shadow_poll_interval};
        end
        else if (shadow_mode != MODE_IDLE && deadline_reached(w.now_time, shadow_next_poll))
        begin
            shadow_next_poll = w.now_time + {1'b0, shadow_poll_interval};
            if (w.link_up)
            begin
                if (shadow_mode != MODE_UP)
                begin
                    shadow_address = w.link_address;
                    shadow_mode    = MODE_UP;
                end
            end
            else if (shadow_mode == MODE_UP)
                drop_link(w.now_time);
            else if (shadow_mode == MODE_CONNECTING)
            begin
                if (w.link_failed || deadline_reached(w.now_time, shadow_join_at))
                    drop_link(w.now_time);
            end
            else if (deadline_reached(w.now_time, shadow_retry_at))
            begin
                start_attempt(w.now_time, w.connect_accepted);
                req = 1'b1;
            end
        end
        r.link_state      = shadow_mode;
        r.connect_request = req;
        r.held_address    = (shadow_mode == MODE_UP) ? shadow_address : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_status(ljs_result_t got);
        ljs_result_t want;
        if (pending_status.size() == 0)
        begin
            report_mismatch($sformatf("status word with nothing expected: state %0d req %0d addr %h",
                got.link_state, got.connect_request, got.held_address));
            return;
        end
        want = pending_status.pop_front();
        if (got.link_state !== want.link_state)
            report_mismatch($sformatf("link_state %0d, expected %0d",
                got.link_state, want.link_state));
        if (got.connect_request !== want.connect_request)
            report_mismatch($sformatf("connect_request %0d, expected %0d",
                got.connect_request, want.connect_request));
        if (got.held_address !== want.held_address)
            report_mismatch($sformatf("held_address %h, expected %h",
                got.held_address, want.held_address));
    endtask

    // Status side: checks each accepted word and throttles ready.
    initial
    begin
        int stall_left;
        int hold_left;
        ljs_result_t got;
        stall_left = 0;
        hold_left  = 0;
        status_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && status_if.valid && status_if.ready)
            begin
                got.link_state      = status_if.link_state;
                got.connect_request = status_if.connect_request;
                got.held_address    = status_if.held_address;
                check_status(got);
            end
            if (squeeze_req)
            begin
                squeeze_req = 0;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                status_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                status_if.ready <= 1'b0;
            end
            else
                status_if.ready <= 1'b1;
        end
    end

    function automatic void add_row(bit c, logic [31:0] t, bit up, bit fl, bit acc,
                                    logic [31:0] addr, bit typed, mode_t st, bit req,
                                    logic [31:0] held);
        stim_row_t r;
        r.word.cmd              = c;
        r.word.now_time         = t;
        r.word.link_up          = up;
        r.word.link_failed      = fl;
        r.word.connect_accepted = acc;
        r.word.link_address     = addr;
        r.typed                 = typed;
        r.status.link_state     = st;
        r.status.connect_request = req;
        r.status.held_address   = held;
        directed_rows.push_back(r);
    endfunction

    task automatic send_word(ljs_item_t w, bit typed, ljs_result_t typed_status);
        ljs_result_t predicted;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.cmd              <= w.cmd;
        cmd_if.now_time         <= w.now_time;
        cmd_if.link_up          <= w.link_up;
        cmd_if.link_failed      <= w.link_failed;
        cmd_if.connect_accepted <= w.connect_accepted;
        cmd_if.link_address     <= w.link_address;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        predicted = supervise_step(w);
        pending_status.push_back(typed ? typed_status : predicted);
    endtask

    // Mostly a plausible timeline of polls and starts; the rest is unrelated noise.
    function automatic ljs_item_t next_word();
        ljs_item_t   w;
        logic [31:0] step;
        int          pick;
        if ($urandom_range(0, 99) < 15)
        begin
            w.cmd              = 1'($urandom_range(0, 1));
            w.now_time         = $urandom;
            w.link_up          = 1'($urandom_range(0, 1));
            w.link_failed      = 1'($urandom_range(0, 1));
            w.connect_accepted = 1'($urandom_range(0, 1));
            w.link_address     = $urandom;
            return w;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2)
            step = $urandom_range(0, {1'b0, shadow_poll_interval} - 1);
        else if (pick < 8)
            step = {1'b0, shadow_poll_interval} + $urandom_range(0, 3);
        else if (pick == 8)
            step = {1'b0, shadow_retry_wait} + $urandom_range(0, 1);
        else
            step = {1'b0, shadow_join_timeout} + $urandom_range(0, 1);
        gen_time = gen_time + step;
        w.now_time = gen_time;
        if (shadow_mode == MODE_IDLE)
            w.cmd = 1'($urandom_range(0, 1));
        else
            w.cmd = ($urandom_range(0, 9) == 0);
        w.link_up          = ($urandom_range(0, 9) < 3);
        w.link_failed      = ($urandom_range(0, 3) == 0);
        w.connect_accepted = ($urandom_range(0, 9) < 6);
        w.link_address     = $urandom;
        return w;
    endfunction

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] poll, logic [CFG_DATA_W-1:0] retry,
                                logic [CFG_DATA_W-1:0] join_ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLL_INTERVAL;
        cfg_data  <= poll;
        @(posedge clk);
        shadow_poll_interval = poll;
        cfg_index <= CFG_RETRY_WAIT;
        cfg_data  <= retry;
        @(posedge clk);
        shadow_retry_wait = retry;
        cfg_index <= CFG_JOIN_TIMEOUT;
        cfg_data  <= join_ms;
        @(posedge clk);
        shadow_join_timeout = join_ms;
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] poll, logic [CFG_DATA_W-1:0] retry,
                             logic [CFG_DATA_W-1:0] join_ms, int count, bit squeeze);
        ljs_result_t none;
        none = '0;
        wait_idle();
        program_regs(poll, retry, join_ms);
        if (squeeze)
            squeeze_req = 1;
        repeat (count) send_word(next_word(), 1'b0, none);
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_POLL_INTERVAL;
        cfg_data                <= '0;
        cmd_if.valid            <= 1'b0;
        cmd_if.cmd              <= 1'b0;
        cmd_if.now_time         <= '0;
        cmd_if.link_up          <= 1'b0;
        cmd_if.link_failed      <= 1'b0;
        cmd_if.connect_accepted <= 1'b0;
        cmd_if.link_address     <= '0;

        // Default registers: poll 1000, retry 10000, join 15000.
        add_row(1'b0, 32'd0, 0, 0, 0, 32'd0, 1, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFFF, 1, MODE_IDLE, 0, 32'd0);
        add_row(1'b1, 32'd0, 0, 0, 1, 32'd0, 1, MODE_CONNECTING, 1, 32'd0);
        add_row(1'b0, 32'd999, 1, 0, 0, 32'h0000_AAAA, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd1000, 1, 1, 0, 32'hFFFF_FFFF, 1, MODE_UP, 0, 32'hFFFF_FFFF);
        add_row(1'b0, 32'd2000, 1, 0, 0, 32'h1234_5678, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd3000, 0, 0, 0, 32'd0, 1, MODE_DOWN, 0, 32'd0);
        add_row(1'b0, 32'd4000, 0, 0, 1, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd13000, 0, 0, 0, 32'd0, 1, MODE_DOWN, 1, 32'd0);
        add_row(1'b0, 32'd23000, 0, 0, 1, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd24000, 0, 1, 0, 32'd0, 1, MODE_DOWN, 0, 32'd0);
        add_row(1'b1, 32'd25000, 0, 0, 1, 32'd0, 1, MODE_CONNECTING, 1, 32'd0);
        add_row(1'b0, 32'd26000, 0, 0, 0, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd40000, 0, 0, 0, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b1, 32'd41000, 0, 0, 1, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'd42000, 1, 0, 0, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b1, 32'd43000, 0, 0, 0, 32'd0, 1, MODE_DOWN, 1, 32'd0);
        add_row(1'b1, 32'd44000, 0, 0, 1, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'h8000_AFC8, 1, 0, 0, 32'h5A5A_A5A5, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'h8000_AFC7, 1, 0, 0, 32'h5A5A_A5A5, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'h8000_B3AF, 0, 1, 1, 32'd0, 0, MODE_IDLE, 0, 32'd0);
        add_row(1'b0, 32'h8000_B797, 0, 1, 0, 32'd0, 0, MODE_IDLE, 0, 32'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].status);

        gen_time = 32'hFFFF_FF80;
        run_phase(31'd1, 31'd1, 31'd1, 110, 1'b0);
        run_phase(31'd7, 31'd40, 31'd60, 120, 1'b1);
        run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 100, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(1, 50)), CFG_DATA_W'($urandom_range(1, 300)),
                  CFG_DATA_W'($urandom_range(1, 300)), 120, 1'b0);
        quiet = 1;
        run_phase(POLL_INTERVAL_RESET, RETRY_WAIT_RESET, JOIN_TIMEOUT_RESET, 100, 1'b0);

        cmd_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ljs_pkg.sv
rtl/ljs_ifs.sv
rtl/ljs_cfg.sv
rtl/ljs_core.sv
rtl/link_join_supervisor.sv
test/tb_link_join_supervisor.sv
